@@ rtl/ttf_pkg.sv @@
// Shared constants and types for the triangle tangent frame block
package ttf_pkg;

   localparam int POS_WIDTH_DEF = 16;
   localparam int UV_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 32;
   localparam int POS_FRAC      = 8;
   localparam int UV_FRAC       = 12;
   localparam int OUT_FRAC      = 16;
   localparam int DIV_SHIFT     = UV_FRAC - POS_FRAC + OUT_FRAC;

   typedef enum logic [3:0] {
      OP_NUM   = 4'd0,
      OP_DIV   = 4'd1,
      OP_CROSS = 4'd2,
      OP_ZERO  = 4'd3
   } op_type;

   typedef struct packed {
      logic   load_corner;
      logic   corner_sel;
      logic   start_frame;
      op_type op;
      logic   op_go;
      logic   [3:0] slot;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic op_done;
   } sts_type;

endpackage

@@ rtl/ttf_datapath.sv @@
// Datapath: corner store, edge terms, shared divider and cross-product unit
module ttf_datapath #(
   parameter int POS_WIDTH = ttf_pkg::POS_WIDTH_DEF,
   parameter int UV_WIDTH  = ttf_pkg::UV_WIDTH_DEF,
   parameter int OUT_WIDTH = ttf_pkg::OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ttf_pkg::cmd_type            cmd,
   output ttf_pkg::sts_type            sts,
   input  logic signed [POS_WIDTH-1:0] pos_x,
   input  logic signed [POS_WIDTH-1:0] pos_y,
   input  logic signed [POS_WIDTH-1:0] pos_z,
   input  logic signed [UV_WIDTH-1:0]  tex_u,
   input  logic signed [UV_WIDTH-1:0]  tex_v,
   output logic signed [OUT_WIDTH-1:0] frame [9],
   output logic                        degenerate
);
   localparam int EW = POS_WIDTH + 1;
   localparam int DW = UV_WIDTH + 1;
   localparam int PW = EW + DW + 1;
   localparam int NW = PW + 1;
   localparam int DETW = 2 * DW + 1;
   localparam int QW = OUT_WIDTH + 1;
   localparam int DSH = ttf_pkg::DIV_SHIFT;
   localparam int ITER = NW + DSH;
   localparam int RW = DETW + 1;
   localparam int CW = 2 * OUT_WIDTH + 1;
   localparam int IW = $clog2(ITER + 1);

   logic signed [POS_WIDTH-1:0] hp_ff [2][3];
   logic signed [UV_WIDTH-1:0]  ht_ff [2][2];
   logic signed [EW-1:0] q1_ff [3], q2_ff [3];
   logic signed [DW-1:0] s1_ff, t1_ff, s2_ff, t2_ff;
   logic signed [DETW-1:0] det_ff;
   logic signed [NW-1:0] num_ff [6];
   logic signed [OUT_WIDTH-1:0] res_ff [9];
   logic signed [OUT_WIDTH-1:0] out_ff [9];
   logic deg_ff;
   logic [1:0] phase_ff;

   logic [NW+DSH-1:0] dvd_ff;
   logic [RW-1:0] rem_ff;
   logic [IW-1:0] cnt_ff;
   logic busy_ff, neg_ff, ovf_ff, done_ff;
   logic [QW:0] quo_ff;
   logic [3:0] slot_ff;
   logic signed [CW-1:0] prod_ff;
   logic [1:0] cstep_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_corner) begin
         hp_ff[cmd.corner_sel][0] <= pos_x;
         hp_ff[cmd.corner_sel][1] <= pos_y;
         hp_ff[cmd.corner_sel][2] <= pos_z;
         ht_ff[cmd.corner_sel][0] <= tex_u;
         ht_ff[cmd.corner_sel][1] <= tex_v;
      end
      if (cmd.start_frame) begin
         q1_ff[0] <= EW'(hp_ff[1][0]) - EW'(hp_ff[0][0]);
         q1_ff[1] <= EW'(hp_ff[1][1]) - EW'(hp_ff[0][1]);
         q1_ff[2] <= EW'(hp_ff[1][2]) - EW'(hp_ff[0][2]);
         q2_ff[0] <= EW'(pos_x) - EW'(hp_ff[0][0]);
         q2_ff[1] <= EW'(pos_y) - EW'(hp_ff[0][1]);
         q2_ff[2] <= EW'(pos_z) - EW'(hp_ff[0][2]);
         s1_ff <= DW'(ht_ff[1][0]) - DW'(ht_ff[0][0]);
         t1_ff <= DW'(ht_ff[1][1]) - DW'(ht_ff[0][1]);
         s2_ff <= DW'(tex_u) - DW'(ht_ff[0][0]);
         t2_ff <= DW'(tex_v) - DW'(ht_ff[0][1]);
      end
   end

   // numerator and determinant phase: all products are combinational and registered together
   logic signed [DETW-1:0] det_in;
   logic signed [PW-1:0] pa [3], pb [3];
   always_comb begin
      det_in = DETW'(s1_ff * t2_ff) - DETW'(s2_ff * t1_ff);
      for (int i = 0; i < 3; i++) begin
         pa[i] = PW'(q1_ff[i] * t2_ff) - PW'(q2_ff[i] * t1_ff);
         pb[i] = PW'(q2_ff[i] * s1_ff) - PW'(q1_ff[i] * s2_ff);
      end
   end

   logic num_done;
   assign num_done = cmd.op_go && cmd.op == ttf_pkg::OP_NUM;

   always_ff @(posedge clock) begin
      if (num_done) begin
         det_ff <= det_in;
         for (int i = 0; i < 3; i++) begin
            num_ff[i]     <= NW'(pa[i]);
            num_ff[3 + i] <= NW'(pb[i]);
         end
      end
   end

   // restoring divider on magnitudes
   logic [NW-1:0] nsel;
   logic [DETW-1:0] dmag;
   logic [RW-1:0] rsh;
   logic [QW:0] qlim;
   logic [QW:0] qnext;
   logic rge;
   logic signed [OUT_WIDTH-1:0] omax, omin, dres;
   always_comb begin
      nsel  = num_ff[cmd.slot[2:0] > 3'd5 ? 3'd0 : cmd.slot[2:0]];
      dmag  = det_ff[DETW-1] ? DETW'(-det_ff) : det_ff;
      rsh   = {rem_ff[RW-2:0], dvd_ff[NW+DSH-1]};
      rge   = rsh >= RW'(dmag);
      qlim  = (QW+1)'(1) << (OUT_WIDTH - 1);
      qnext = {quo_ff[QW-1:0], rge};
      omax  = {1'b0, {(OUT_WIDTH-1){1'b1}}};
      omin  = {1'b1, {(OUT_WIDTH-1){1'b0}}};
      if (neg_ff)
         dres = ovf_ff ? omin : OUT_WIDTH'(-quo_ff);
      else
         dres = (ovf_ff || quo_ff > qlim - 1'b1) ? omax : OUT_WIDTH'(quo_ff);
   end

   // cross product: two multiplies in sequence, the second subtracted from the first
   logic signed [OUT_WIDTH-1:0] ca, cb;
   logic [3:0] ia, ib, ja, jb;
   logic signed [CW-1:0] sh;
   logic signed [OUT_WIDTH-1:0] cres;
   always_comb begin
      case (slot_ff)
         4'd7: begin
            ia = 4'd2; ib = 4'd3; ja = 4'd0; jb = 4'd5;
         end
         4'd8: begin
            ia = 4'd0; ib = 4'd4; ja = 4'd1; jb = 4'd3;
         end
         default: begin
            ia = 4'd1; ib = 4'd5; ja = 4'd2; jb = 4'd4;
         end
      endcase
      if (cstep_ff == 2'd0) begin
         ca = res_ff[ia];
         cb = res_ff[ib];
      end else begin
         ca = res_ff[ja];
         cb = res_ff[jb];
      end
      sh = prod_ff >>> ttf_pkg::OUT_FRAC;
      if (sh > CW'(omax))      cres = omax;
      else if (sh < CW'(omin)) cres = omin;
      else                     cres = OUT_WIDTH'(sh);
   end

   logic fin;
   assign fin = busy_ff && (phase_ff != 2'd0 ? cstep_ff == 2'd2 : cnt_ff == IW'(ITER));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cstep_ff <= 2'd0;
         phase_ff <= 2'd0;
      end else begin
         done_ff <= num_done || fin;
         if (cmd.op_go && cmd.op == ttf_pkg::OP_DIV) begin
            busy_ff <= 1'b1;
            slot_ff <= cmd.slot;
            neg_ff  <= nsel[NW-1] != det_ff[DETW-1];
            dvd_ff  <= {(nsel[NW-1] ? NW'(-nsel) : nsel), {DSH{1'b0}}};
            rem_ff  <= '0;
            quo_ff  <= '0;
            ovf_ff  <= 1'b0;
            cnt_ff  <= '0;
         end else if (cmd.op_go && cmd.op == ttf_pkg::OP_CROSS) begin
            busy_ff  <= 1'b1;
            slot_ff  <= cmd.slot;
            cstep_ff <= 2'd0;
            phase_ff <= 2'd1;
         end else if (busy_ff && phase_ff != 2'd0) begin
            if (cstep_ff == 2'd0) begin
               prod_ff  <= CW'(ca * cb);
               cstep_ff <= 2'd1;
            end else if (cstep_ff == 2'd1) begin
               prod_ff  <= prod_ff - CW'(ca * cb);
               cstep_ff <= 2'd2;
            end else begin
               res_ff[slot_ff] <= cres;
               busy_ff  <= 1'b0;
               phase_ff <= 2'd0;
               cstep_ff <= 2'd0;
            end
         end else if (busy_ff) begin
            if (cnt_ff == IW'(ITER)) begin
               res_ff[slot_ff] <= dres;
               busy_ff <= 1'b0;
            end else begin
               dvd_ff <= dvd_ff << 1;
               rem_ff <= rge ? rsh - RW'(dmag) : rsh;
               quo_ff <= qnext;
               if (qnext > qlim) ovf_ff <= 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int i = 0; i < 9; i++)
            out_ff[i] <= cmd.op == ttf_pkg::OP_ZERO ? '0 : res_ff[i];
         deg_ff <= cmd.op == ttf_pkg::OP_ZERO;
      end
   end

   assign sts.det_zero = det_ff == '0;
   assign sts.op_done  = done_ff;
   assign frame        = out_ff;
   assign degenerate   = deg_ff;
endmodule

@@ rtl/ttf_control.sv @@
// Controller: corner count, operation sequencing and result handshake
module ttf_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttf_pkg::cmd_type cmd,
   input  ttf_pkg::sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_NUM   = 6'b000010,
      S_ISSUE = 6'b000100,
      S_WAIT  = 6'b001000,
      S_OUT   = 6'b010000,
      S_HOLD  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] count_ff, count_in;
   logic [3:0] slot_ff, slot_in;
   logic first_ff, first_in;
   logic rv_ff, rv_in;
   logic accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      first_in = first_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      cmd.op   = ttf_pkg::OP_NUM;
      cmd.slot = slot_ff;
      cmd.corner_sel = count_ff[0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff == 2'd2) begin
                  count_in        = 2'd0;
                  cmd.start_frame = 1'b1;
                  state_in        = S_NUM;
               end else begin
                  cmd.load_corner = 1'b1;
                  count_in        = count_ff + 2'd1;
               end
            end
         end
         S_NUM: begin
            cmd.op    = ttf_pkg::OP_NUM;
            cmd.op_go = 1'b1;
            slot_in   = 4'd0;
            first_in  = 1'b1;
            state_in  = S_WAIT;
         end
         S_ISSUE: begin
            cmd.op    = slot_ff < 4'd6 ? ttf_pkg::OP_DIV : ttf_pkg::OP_CROSS;
            cmd.op_go = 1'b1;
            first_in  = 1'b0;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (sts.op_done) begin
               if (first_ff) begin
                  state_in = sts.det_zero ? S_OUT : S_ISSUE;
               end else if (slot_ff == 4'd8) begin
                  state_in = S_OUT;
               end else begin
                  slot_in  = slot_ff + 4'd1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.op       = sts.det_zero ? ttf_pkg::OP_ZERO : ttf_pkg::OP_NUM;
               rv_in        = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= 2'd0;
         slot_ff  <= 4'd0;
         first_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
         first_ff <= first_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

@@ rtl/triangle_tangent_frame.sv @@
// Top level of the triangle tangent frame block
// Corners one and two are stored as they are taken; the third corner starts the
// frame: numerators and determinant, six serial divisions of ITER = 56 shift steps,
// three cross products, then the result word; a zero determinant goes to the word.
// New corners stall until the word is loaded, which waits while the result stalls.
// Reset clears the corner count and the result valid.
module triangle_tangent_frame #(
   parameter int POS_WIDTH = ttf_pkg::POS_WIDTH_DEF,
   parameter int UV_WIDTH  = ttf_pkg::UV_WIDTH_DEF,
   parameter int OUT_WIDTH = ttf_pkg::OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_WIDTH-1:0] req_pos_x,
   input  logic signed [POS_WIDTH-1:0] req_pos_y,
   input  logic signed [POS_WIDTH-1:0] req_pos_z,
   input  logic signed [UV_WIDTH-1:0]  req_tex_u,
   input  logic signed [UV_WIDTH-1:0]  req_tex_v,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_x,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_y,
   output logic signed [OUT_WIDTH-1:0] rsp_tangent_z,
   output logic signed [OUT_WIDTH-1:0] rsp_bitangent_x,
   output logic signed [OUT_WIDTH-1:0] rsp_bitangent_y,
   output logic signed [OUT_WIDTH-1:0] rsp_bitangent_z,
   output logic signed [OUT_WIDTH-1:0] rsp_normal_x,
   output logic signed [OUT_WIDTH-1:0] rsp_normal_y,
   output logic signed [OUT_WIDTH-1:0] rsp_normal_z,
   output logic                        rsp_degenerate
);
   ttf_pkg::cmd_type cmd;
   ttf_pkg::sts_type sts;
   logic signed [OUT_WIDTH-1:0] frame [9];

   ttf_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd, .sts
   );

   ttf_datapath #(
      .POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH), .OUT_WIDTH(OUT_WIDTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts,
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .tex_u(req_tex_u), .tex_v(req_tex_v),
      .frame, .degenerate(rsp_degenerate)
   );

   assign rsp_tangent_x   = frame[0];
   assign rsp_tangent_y   = frame[1];
   assign rsp_tangent_z   = frame[2];
   assign rsp_bitangent_x = frame[3];
   assign rsp_bitangent_y = frame[4];
   assign rsp_bitangent_z = frame[5];
   assign rsp_normal_x    = frame[6];
   assign rsp_normal_y    = frame[7];
   assign rsp_normal_z    = frame[8];
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the triangle tangent frame block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW = ttf_pkg::POS_WIDTH_DEF;
   localparam int UW = ttf_pkg::UV_WIDTH_DEF;
   localparam int OW = ttf_pkg::OUT_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [PW-1:0] px, py, pz;
      logic signed [UW-1:0] u, v;
   } corner_type;

   typedef struct {
      logic signed [OW-1:0] f [9];
      logic                 degen;
   } frame_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [PW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [UW-1:0] req_tex_u = '0, req_tex_v = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OW-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic signed [OW-1:0] rsp_bitangent_x, rsp_bitangent_y, rsp_bitangent_z;
   logic signed [OW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   corner_type pending_corners[$];
   frame_type  expected_frames[$];
   corner_type held [2];
   int      corner_count = 0;
   int      fail_count = 0;
   int      watchdog = 0;
   bit      stim_done = 0;
   bit      calm = 0;
   int      req_gap = 0, rsp_gap = 0;

   always #2 clock = ~clock;

   triangle_tangent_frame dut (.*);

   function automatic longint scaled_quotient(longint num, longint det);
      logic signed [127:0] n, q;
      n = 128'(signed'(num)) <<< ttf_pkg::DIV_SHIFT;
      q = n / 128'(signed'(det));
      if (q > 128'sd2147483647) return 64'sd2147483647;
      if (q < -128'sd2147483648) return -64'sd2147483648;
      return longint'(q);
   endfunction

   function automatic longint cross_floor(longint a, longint b, longint c, longint d);
      logic signed [127:0] r;
      r = 128'(signed'(a)) * 128'(signed'(b)) - 128'(signed'(c)) * 128'(signed'(d));
      r = r >>> ttf_pkg::OUT_FRAC;
      if (r > 128'sd2147483647) return 64'sd2147483647;
      if (r < -128'sd2147483648) return -64'sd2147483648;
      return longint'(r);
   endfunction

   task automatic predict_corner(corner_type c);
      longint q1 [3], q2 [3], t [3], b [3];
      longint s1, t1, s2, t2, det;
      frame_type fr;
      if (corner_count < 2) begin
         held[corner_count] = c;
         corner_count++;
         return;
      end
      corner_count = 0;
      q1[0] = longint'(held[1].px) - held[0].px;
      q1[1] = longint'(held[1].py) - held[0].py;
      q1[2] = longint'(held[1].pz) - held[0].pz;
      q2[0] = longint'(c.px) - held[0].px;
      q2[1] = longint'(c.py) - held[0].py;
      q2[2] = longint'(c.pz) - held[0].pz;
      s1 = longint'(held[1].u) - held[0].u;
      t1 = longint'(held[1].v) - held[0].v;
      s2 = longint'(c.u) - held[0].u;
      t2 = longint'(c.v) - held[0].v;
      det = s1 * t2 - s2 * t1;
      if (det == 0) begin
         foreach (fr.f[i]) fr.f[i] = '0;
         fr.degen = 1'b1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            t[i] = scaled_quotient(q1[i] * t2 - q2[i] * t1, det);
            b[i] = scaled_quotient(q2[i] * s1 - q1[i] * s2, det);
            fr.f[i] = OW'(t[i]);
            fr.f[3 + i] = OW'(b[i]);
         end
         fr.f[6] = OW'(cross_floor(t[1], b[2], t[2], b[1]));
         fr.f[7] = OW'(cross_floor(t[2], b[0], t[0], b[2]));
         fr.f[8] = OW'(cross_floor(t[0], b[1], t[1], b[0]));
         fr.degen = 1'b0;
      end
      expected_frames.push_back(fr);
   endtask

   function automatic corner_type mk(int x, int y, int z, int u, int v);
      corner_type c;
      c.px = PW'(x); c.py = PW'(y); c.pz = PW'(z); c.u = UW'(u); c.v = UW'(v);
      return c;
   endfunction

   function automatic corner_type rand_corner(int span);
      corner_type c;
      if (span == 0) begin
         c = mk($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         c = mk($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                $urandom_range(2 * span) - span);
      end
      return c;
   endfunction

   initial begin
      corner_type c;
      int span;
      // unit triangle, then degenerate (collinear and repeated texcoords)
      pending_corners.push_back(mk(0, 0, 0, 0, 0));
      pending_corners.push_back(mk(256, 0, 0, 4096, 0));
      pending_corners.push_back(mk(0, 256, 0, 0, 4096));
      pending_corners.push_back(mk(1, 2, 3, 100, 100));
      pending_corners.push_back(mk(4, 5, 6, 100, 100));
      pending_corners.push_back(mk(7, 8, 9, 100, 100));
      pending_corners.push_back(mk(0, 0, 0, 0, 0));
      pending_corners.push_back(mk(0, 0, 0, 1, 1));
      pending_corners.push_back(mk(0, 0, 0, 2, 2));
      // field extremes, saturating frames
      pending_corners.push_back(mk(-32768, -32768, -32768, 0, 0));
      pending_corners.push_back(mk(32767, 32767, 32767, 1, 0));
      pending_corners.push_back(mk(32767, -32768, 32767, 0, 1));
      pending_corners.push_back(mk(32767, 32767, -32768, -32768, -32768));
      pending_corners.push_back(mk(-32768, -32768, 32767, 32767, -32768));
      pending_corners.push_back(mk(-32768, 32767, -32768, -32768, 32767));
      pending_corners.push_back(mk(0, 0, 0, -32768, 32767));
      pending_corners.push_back(mk(-32768, 32767, 0, 32767, 32767));
      pending_corners.push_back(mk(32767, -32768, -1, -32768, -32768));
      pending_corners.push_back(mk(-1, -1, -1, -1, -1));
      pending_corners.push_back(mk(0, 0, 0, -1, -1));
      pending_corners.push_back(mk(1, 1, 1, 0, -1));
      for (int i = 0; i < 1680; i++) begin
         case ($urandom_range(3))
            0: span = 0;
            1: span = 300;
            2: span = 8000;
            default: span = 20;
         endcase
         c = rand_corner(span);
         if ($urandom_range(15) == 0) c.u = pending_corners[$].u;
         pending_corners.push_back(c);
      end
      stim_done = 1;
   end

   // driver
   always @(posedge clock) begin
      corner_type c;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) predict_corner(mk(req_pos_x, req_pos_y, req_pos_z,
                                                         req_tex_u, req_tex_v));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 0;
            end else if (!calm && $urandom_range(5) == 0) begin
               req_gap = $urandom_range(3);
               req_valid <= 0;
            end else if (pending_corners.size() > 0) begin
               c = pending_corners.pop_front();
               req_valid <= 1;
               req_pos_x <= c.px; req_pos_y <= c.py; req_pos_z <= c.pz;
               req_tex_u <= c.u; req_tex_v <= c.v;
            end else begin
               req_valid <= 0;
            end
         end
         calm <= stim_done && pending_corners.size() < 200;
      end
   end

   // stall
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(3) == 0) begin
         rsp_gap = $urandom_range(3);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.f = '{rsp_tangent_x, rsp_tangent_y, rsp_tangent_z,
                   rsp_bitangent_x, rsp_bitangent_y, rsp_bitangent_z,
                   rsp_normal_x, rsp_normal_y, rsp_normal_z};
         got.degen = rsp_degenerate;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected word", $time);
            fail_count++;
         end else begin
            want = expected_frames.pop_front();
            foreach (got.f[i])
               if (got.f[i] !== want.f[i]) begin
                  $display("%0t: field %0d expected %0d actual %0d", $time, i,
                           want.f[i], got.f[i]);
                  fail_count++;
               end
            if (got.degen !== want.degen) begin
               $display("%0t: degenerate expected %0d actual %0d", $time,
                        want.degen, got.degen);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (stim_done && pending_corners.size() == 0);
      @(posedge clock);
      while (req_valid || expected_frames.size() > 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/ttf_pkg.sv
rtl/ttf_datapath.sv
rtl/ttf_control.sv
rtl/triangle_tangent_frame.sv
tb/sv/testbench.sv
